// ===== src/sac_pkg.sv =====
package sac_pkg;

  // Pixel and result field widths
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PIX_W  = 3 * CHAN_W;
  localparam int unsigned DISP_W = 6;
  localparam int unsigned RAW_W  = 10;
  localparam int unsigned NORM_W = 16;

  // Default number of disparity levels
  localparam int unsigned DISPARITY_LEVELS_DEF = 16;

  // Largest raw cost: three channels at full swing
  localparam logic [RAW_W-1:0] RAW_MAX = RAW_W'(765);

  // Normalization: floor(raw * 257 / 3), the divide done as a reciprocal multiply
  localparam int unsigned     SCALED_W    = 18;
  localparam int unsigned     RECIP_SHIFT = 19;
  localparam logic [SCALED_W-1:0] RECIP_3 = SCALED_W'(174763);

  // Decoupling queue depth between front and back
  localparam int unsigned Q_DEPTH = 2;

  // Absolute difference of two channel values
  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== src/sac_front.sv =====
module sac_front #(
  parameter int unsigned DISPARITY_LEVELS = sac_pkg::DISPARITY_LEVELS_DEF
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                in_valid_i,
  output logic                                                in_stall_o,
  input  logic [sac_pkg::CHAN_W-1:0]                          left_red_i,
  input  logic [sac_pkg::CHAN_W-1:0]                          left_green_i,
  input  logic [sac_pkg::CHAN_W-1:0]                          left_blue_i,
  input  logic [sac_pkg::CHAN_W-1:0]                          right_red_i,
  input  logic [sac_pkg::CHAN_W-1:0]                          right_green_i,
  input  logic [sac_pkg::CHAN_W-1:0]                          right_blue_i,
  input  logic                                                row_start_i,
  input  logic                                                q_full_i,
  output logic                                                push_o,
  output logic [DISPARITY_LEVELS:0][sac_pkg::PIX_W-1:0]       push_data_o
);
  import sac_pkg::*;

  logic                                     accept;
  logic [PIX_W-1:0]                         right_pix;
  logic [DISPARITY_LEVELS-1:0][PIX_W-1:0]   window;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign push_o     = accept;
  assign right_pix  = {right_red_i, right_green_i, right_blue_i};

  // Snapshot the left pixel and every candidate right pixel for this beat
  assign push_data_o = {window, left_red_i, left_green_i, left_blue_i};

  if (DISPARITY_LEVELS > 1) begin : g_hist
    logic [DISPARITY_LEVELS-2:0][PIX_W-1:0] hist_q;

    // Build the window: current right pixel, then history (refilled at row start)
    always_comb begin
      window[0] = right_pix;
      for (int unsigned k = 1; k < DISPARITY_LEVELS; k++) begin
        window[k] = row_start_i ? right_pix : hist_q[k-1];
      end
    end

    // Advance the delay line by one column per accepted beat
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hist_q <= '0;
      end else if (accept) begin
        hist_q <= window[DISPARITY_LEVELS-2:0];
      end
    end
  end else begin : g_no_hist
    assign window[0] = right_pix;
  end

endmodule

// ===== src/sac_queue.sv =====
module sac_queue #(
  parameter int unsigned WIDTH = sac_pkg::PIX_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             head_valid_o,
  output logic [WIDTH-1:0] head_data_o,
  input  logic             pop_i
);
  import sac_pkg::*;

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  logic [Q_DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PTR_W-1:0]              wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]              count_q;

  assign full_o       = (count_q == CNT_W'(Q_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_o |-> !pop_i) else $error("queue popped while empty");

endmodule

// ===== src/sac_back.sv =====
module sac_back #(
  parameter int unsigned DISPARITY_LEVELS = sac_pkg::DISPARITY_LEVELS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          head_valid_i,
  input  logic [DISPARITY_LEVELS:0][sac_pkg::PIX_W-1:0] head_data_i,
  output logic                                          pop_o,
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output logic [sac_pkg::DISP_W-1:0]                    disparity_o,
  output logic [sac_pkg::RAW_W-1:0]                     raw_cost_o,
  output logic [sac_pkg::NORM_W-1:0]                    norm_cost_o,
  output logic                                          last_level_o
);
  import sac_pkg::*;

  localparam int unsigned DW = (DISPARITY_LEVELS > 1) ? $clog2(DISPARITY_LEVELS) : 1;
  localparam int unsigned IW = $clog2(DISPARITY_LEVELS + 1);
  localparam logic [DW-1:0] D_LAST = DW'(DISPARITY_LEVELS - 1);

  logic [DW-1:0]   d_q;
  logic            s1_valid_q, s1_last_q;
  logic [DISP_W-1:0] s1_disp_q;
  logic [RAW_W-1:0]  s1_raw_q;
  logic            out_valid_q, out_last_q;
  logic [DISP_W-1:0] out_disp_q;
  logic [RAW_W-1:0]  out_raw_q;
  logic [NORM_W-1:0] out_norm_q;

  logic               advance, issue, is_last;
  logic [IW-1:0]      sel;
  logic [PIX_W-1:0]   left_pix, right_pix;
  logic [RAW_W-1:0]   raw_cost;
  logic [SCALED_W-1:0] scaled;
  logic [2*SCALED_W-1:0] product;

  // Whole pipeline holds while the output beat is stalled
  assign advance = ~(out_valid_q & out_stall_i);
  assign issue   = advance & head_valid_i;
  assign is_last = (d_q == D_LAST);
  assign pop_o   = issue & is_last;

  // Pick the left pixel and the right pixel d columns back
  assign sel       = IW'(d_q) + IW'(1);
  assign left_pix  = head_data_i[0];
  assign right_pix = head_data_i[sel];

  assign raw_cost =
      RAW_W'(abs_diff(left_pix[3*CHAN_W-1:2*CHAN_W], right_pix[3*CHAN_W-1:2*CHAN_W]))
    + RAW_W'(abs_diff(left_pix[2*CHAN_W-1:CHAN_W],   right_pix[2*CHAN_W-1:CHAN_W]))
    + RAW_W'(abs_diff(left_pix[CHAN_W-1:0],          right_pix[CHAN_W-1:0]));

  // raw * 257, then divide by three through the reciprocal
  assign scaled  = SCALED_W'({s1_raw_q, 8'h00}) + SCALED_W'(s1_raw_q);
  assign product = scaled * RECIP_3;

  // Step the disparity counter, wrap after the last level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= '0;
    end else if (issue) begin
      d_q <= is_last ? '0 : d_q + DW'(1);
    end
  end

  // Valid bits of the cost stage and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= head_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  // Payload of the cost stage and the output register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_disp_q  <= DISP_W'(d_q);
      s1_raw_q   <= raw_cost;
      s1_last_q  <= is_last;
      out_disp_q <= s1_disp_q;
      out_raw_q  <= s1_raw_q;
      out_last_q <= s1_last_q;
      out_norm_q <= product[RECIP_SHIFT +: NORM_W];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign disparity_o  = out_disp_q;
  assign raw_cost_o   = out_raw_q;
  assign norm_cost_o  = out_norm_q;
  assign last_level_o = out_last_q;

  a_last_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_level_o) |-> (disparity_o == DISP_W'(DISPARITY_LEVELS - 1)))
    else $error("last flag on wrong disparity");
  a_raw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (raw_cost_o <= RAW_MAX)) else $error("raw cost out of range");
  a_d_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_q <= D_LAST) else $error("disparity counter out of range");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (d_q == '0)) else $error("counter not wrapped after pop");

endmodule

// ===== src/stereo_ad_cost_volume.sv =====
// Pipeline: an accepted beat passes the queue, the cost stage and the output
//   register in that order before its first result shows on the output.
// Throughput: DISPARITY_LEVELS costs per pixel, one cost per cycle while the output
//   is not stalled, from the single cost lane stepping the disparity counter;
//   a 2-entry queue decouples input.
// Reset: clears the right-pixel history to black, the queue and all valid bits.
module stereo_ad_cost_volume #(
  parameter int unsigned DISPARITY_LEVELS = sac_pkg::DISPARITY_LEVELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sac_pkg::CHAN_W-1:0]  left_red_i,
  input  logic [sac_pkg::CHAN_W-1:0]  left_green_i,
  input  logic [sac_pkg::CHAN_W-1:0]  left_blue_i,
  input  logic [sac_pkg::CHAN_W-1:0]  right_red_i,
  input  logic [sac_pkg::CHAN_W-1:0]  right_green_i,
  input  logic [sac_pkg::CHAN_W-1:0]  right_blue_i,
  input  logic                        row_start_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sac_pkg::DISP_W-1:0]  disparity_o,
  output logic [sac_pkg::RAW_W-1:0]   raw_cost_o,
  output logic [sac_pkg::NORM_W-1:0]  norm_cost_o,
  output logic                        last_level_o
);
  import sac_pkg::*;

  localparam int unsigned ENTRY_W = PIX_W * (DISPARITY_LEVELS + 1);

  logic                                   q_full, push, head_valid, pop;
  logic [DISPARITY_LEVELS:0][PIX_W-1:0]   push_data, head_data;

  // Accept pixels and build the candidate window
  sac_front #(.DISPARITY_LEVELS(DISPARITY_LEVELS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .left_red_i   (left_red_i),
    .left_green_i (left_green_i),
    .left_blue_i  (left_blue_i),
    .right_red_i  (right_red_i),
    .right_green_i(right_green_i),
    .right_blue_i (right_blue_i),
    .row_start_i  (row_start_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Hold windows between front and back
  sac_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .head_valid_o(head_valid),
    .head_data_o (head_data),
    .pop_i       (pop)
  );

  // Walk the disparity levels and emit costs
  sac_back #(.DISPARITY_LEVELS(DISPARITY_LEVELS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_data_i (head_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .disparity_o (disparity_o),
    .raw_cost_o  (raw_cost_o),
    .norm_cost_o (norm_cost_o),
    .last_level_o(last_level_o)
  );

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sac_pkg::*;

  localparam int unsigned LEVELS      = DISPARITY_LEVELS_DEF;
  localparam int unsigned HIST_DEPTH  = (LEVELS > 1) ? LEVELS - 1 : 0;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_CAP   = 40;

  // One expected cost beat
  typedef struct packed {
    logic [DISP_W-1:0] disparity;
    logic [RAW_W-1:0]  raw_cost;
    logic [NORM_W-1:0] norm_cost;
    logic              last_level;
  } cost_beat_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [CHAN_W-1:0]   left_red    = '0;
  logic [CHAN_W-1:0]   left_green  = '0;
  logic [CHAN_W-1:0]   left_blue   = '0;
  logic [CHAN_W-1:0]   right_red   = '0;
  logic [CHAN_W-1:0]   right_green = '0;
  logic [CHAN_W-1:0]   right_blue  = '0;
  logic                row_start   = 1'b0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [DISP_W-1:0]   disparity;
  logic [RAW_W-1:0]    raw_cost;
  logic [NORM_W-1:0]   norm_cost;
  logic                last_level;

  cost_beat_t          pending_costs[$];
  logic [PIX_W-1:0]    right_line [LEVELS];
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         error_count    = 0;
  int unsigned         pixels_sent    = 0;
  int unsigned         rows_sent      = 0;
  int unsigned         costs_checked  = 0;
  int unsigned         cycle_count    = 0;

  stereo_ad_cost_volume #(
    .DISPARITY_LEVELS(LEVELS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .left_red_i    (left_red),
    .left_green_i  (left_green),
    .left_blue_i   (left_blue),
    .right_red_i   (right_red),
    .right_green_i (right_green),
    .right_blue_i  (right_blue),
    .row_start_i   (row_start),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .disparity_o   (disparity),
    .raw_cost_o    (raw_cost),
    .norm_cost_o   (norm_cost),
    .last_level_o  (last_level)
  );

  // Clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d costs still pending",
               $time, cycle_count, pending_costs.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // Randomly stall the cost channel
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic int unsigned chan_gap(input logic [CHAN_W-1:0] a,
                                           input logic [CHAN_W-1:0] b);
    chan_gap = (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  // Compute the costs of one pixel against the right delay line, then advance it
  task automatic predict_costs(input logic [PIX_W-1:0] left, input logic [PIX_W-1:0] right,
                               input logic start);
    cost_beat_t       beat;
    logic [PIX_W-1:0] ref_pix;
    int unsigned      raw;
    if (start) begin
      for (int k = 0; k < int'(HIST_DEPTH); k++) right_line[k] = right;
    end
    for (int d = 0; d <= int'(HIST_DEPTH); d++) begin
      ref_pix = (d == 0) ? right : right_line[d-1];
      raw = chan_gap(left[23:16], ref_pix[23:16]) + chan_gap(left[15:8], ref_pix[15:8])
          + chan_gap(left[7:0], ref_pix[7:0]);
      beat.disparity  = DISP_W'(d);
      beat.raw_cost   = RAW_W'(raw);
      beat.norm_cost  = NORM_W'((raw * 257) / 3);
      beat.last_level = (d == int'(HIST_DEPTH));
      pending_costs.push_back(beat);
    end
    if (HIST_DEPTH > 0) begin
      for (int k = int'(HIST_DEPTH) - 1; k > 0; k--) right_line[k] = right_line[k-1];
      right_line[0] = right;
    end
  endtask

  // Check each accepted cost beat against the oldest expectation
  always @(posedge clk) begin
    cost_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_costs.size() == 0) begin
        error_count++;
        if (error_count <= PRINT_CAP)
          $display("%0t unexpected cost beat: d=%0d raw=%0d norm=%0d last=%0b",
                   $time, disparity, raw_cost, norm_cost, last_level);
      end else begin
        want = pending_costs.pop_front();
        costs_checked++;
        if (disparity !== want.disparity || raw_cost !== want.raw_cost ||
            norm_cost !== want.norm_cost || last_level !== want.last_level) begin
          error_count++;
          if (error_count <= PRINT_CAP) begin
            if (disparity !== want.disparity)
              $display("%0t disparity: expected %0d, actual %0d",
                       $time, want.disparity, disparity);
            if (raw_cost !== want.raw_cost)
              $display("%0t raw_cost (d=%0d): expected %0d, actual %0d",
                       $time, want.disparity, want.raw_cost, raw_cost);
            if (norm_cost !== want.norm_cost)
              $display("%0t norm_cost (d=%0d): expected %0d, actual %0d",
                       $time, want.disparity, want.norm_cost, norm_cost);
            if (last_level !== want.last_level)
              $display("%0t last_level (d=%0d): expected %0b, actual %0b",
                       $time, want.disparity, want.last_level, last_level);
          end
        end
      end
    end
  end

  // Drive one pixel beat, hold it until accepted
  task automatic send_pixel(input logic [PIX_W-1:0] left, input logic [PIX_W-1:0] right,
                            input logic start);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    left_red    <= left[23:16];
    left_green  <= left[15:8];
    left_blue   <= left[7:0];
    right_red   <= right[23:16];
    right_green <= right[15:8];
    right_blue  <= right[7:0];
    row_start   <= start;
    do @(posedge clk); while (in_stall);
    predict_costs(left, right, start);
    pixels_sent++;
    if (start) rows_sent++;
  endtask

  // Drop valid and wait until every expected cost has come back
  task automatic drain_costs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CHAN_W-1:0] random_chan();
    case ($urandom_range(7))
      0:       random_chan = '0;
      1:       random_chan = '1;
      default: random_chan = CHAN_W'($urandom);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] random_rgb();
    random_rgb = {random_chan(), random_chan(), random_chan()};
  endfunction

  // Right pixel close to the left one, for small costs
  function automatic logic [PIX_W-1:0] near_rgb(input logic [PIX_W-1:0] base);
    logic [PIX_W-1:0] pix;
    for (int c = 0; c < 3; c++)
      pix[c*8 +: 8] = base[c*8 +: 8] + CHAN_W'($urandom_range(6)) - CHAN_W'(3);
    near_rgb = pix;
  endfunction

  // First pixel without a row start compares with a black history
  task automatic test_black_history();
    send_pixel(24'h0A141E, 24'h28323C, 1'b0);
    send_pixel(24'hFFFFFF, 24'h102030, 1'b0);
    drain_costs();
  endtask

  // Full swing, zero cost and single-channel differences
  task automatic test_extremes();
    send_pixel(24'hFFFFFF, 24'h000000, 1'b1);
    send_pixel(24'h000000, 24'hFFFFFF, 1'b1);
    send_pixel(24'h5A5A5A, 24'h5A5A5A, 1'b1);
    send_pixel(24'hFF0000, 24'h000000, 1'b0);
    send_pixel(24'h00FF00, 24'h0000FF, 1'b0);
    send_pixel(24'h000001, 24'h000000, 1'b1);
    drain_costs();
  endtask

  // Short rows: disparities past column zero reuse the first pixel
  task automatic test_row_clamp();
    for (int col = 0; col < 12; col++)
      send_pixel(24'h808080, {8'(col * 20), 8'(255 - col * 20), 8'(col * 7)}, col == 0);
    send_pixel(24'h102030, 24'hF0E0D0, 1'b1);
    send_pixel(24'h102030, 24'h00FF00, 1'b0);
    drain_costs();
  endtask

  // Random rows under one idling pattern
  task automatic test_random_rows(input int unsigned count, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    int unsigned      sent;
    int unsigned      row_len;
    int unsigned      style;
    bit               noisy;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic             start;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < count) begin
      row_len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 20);
      noisy   = ($urandom_range(99) < 15);
      style   = $urandom_range(2);
      for (int col = 0; col < int'(row_len) && sent < count; col++) begin
        left  = random_rgb();
        right = (style == 0) ? near_rgb(left) : random_rgb();
        start = noisy ? ($urandom_range(3) == 0) : (col == 0);
        send_pixel(left, right, start);
        sent++;
      end
    end
    drain_costs();
  endtask

  initial begin
    for (int k = 0; k < int'(LEVELS); k++) right_line[k] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_black_history();
    test_extremes();
    test_row_clamp();
    test_random_rows(100, 0, 0);
    test_random_rows(100, 58, 0);
    test_random_rows(100, 0, 58);
    test_random_rows(100, 38, 38);

    // Let any stray beats show up before closing
    recv_stall_pct = 0;
    repeat (LEVELS + 16) @(posedge clk);

    $display("covered %0d pixels (%0d flagged row starts), %0d cost beats checked",
             pixels_sent, rows_sent, costs_checked);
    $display("over idle, sender-gap, receiver-stall and mixed handshake phases");
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
